@@ design/ecx_pkg.sv @@
// Shared widths, bit positions, register codes and types of the encoder count extender.
package ecx_pkg;

	// Field widths of a sample and of a result beat.
	localparam int RAW_W    = 16;
	localparam int COUNT_W  = 32;
	localparam int GAIN_W   = 32;
	localparam int POS_W    = 64;
	localparam int STATUS_W = 6;
	localparam int SHOWN_W  = 5;
	localparam int CTRL_W   = 4;

	// Status flag bit positions.
	localparam int ST_EXT_LATCH = 3;
	localparam int ST_C_LATCH   = 4;
	localparam int ST_SET_DONE  = 5;

	// Control flag bit positions.
	localparam int CT_SET_RAW     = 0;
	localparam int CT_EN_C        = 1;
	localparam int CT_EN_EXT_POS  = 2;
	localparam int CT_EN_EXT_NEG  = 3;

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic signed [GAIN_W-1:0] GAIN_RESET = 32'sd65536;

	// Register index, taken from the word address.
	typedef enum logic [0:0] {
		REG_GAIN_FIRST  = 1'b0,
		REG_GAIN_SECOND = 1'b1
	} cfg_reg_t;

	// Gains handed from the register block to the datapath.
	typedef struct packed {
		logic signed [GAIN_W-1:0] first;
		logic signed [GAIN_W-1:0] second;
	} gains_t;

endpackage

@@ design/ecx_if.sv @@
// Sample and result channel interfaces of the encoder count extender.
interface ecx_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 channel;
	logic                                 operational;
	logic signed [ecx_pkg::RAW_W-1:0]     raw_sample;
	logic signed [ecx_pkg::RAW_W-1:0]     raw_latched;
	logic        [ecx_pkg::STATUS_W-1:0]  status_flags;
	logic                                 clear_request;
	logic        [ecx_pkg::CTRL_W-1:0]    control_flags;

	modport source (
		output valid, channel, operational, raw_sample, raw_latched,
		       status_flags, clear_request, control_flags,
		input  ready
	);
	modport sink (
		input  valid, channel, operational, raw_sample, raw_latched,
		       status_flags, clear_request, control_flags,
		output ready
	);
endinterface

interface ecx_result_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 channel_echo;
	logic signed [ecx_pkg::COUNT_W-1:0]   extended_count;
	logic signed [ecx_pkg::POS_W-1:0]     position;
	logic signed [ecx_pkg::RAW_W-1:0]     raw_shown;
	logic signed [ecx_pkg::RAW_W-1:0]     latch_shown;
	logic        [ecx_pkg::SHOWN_W-1:0]   status_out;
	logic        [ecx_pkg::CTRL_W-1:0]    control_out;

	modport source (
		output valid, channel_echo, extended_count, position, raw_shown,
		       latch_shown, status_out, control_out,
		input  ready
	);
	modport sink (
		input  valid, channel_echo, extended_count, position, raw_shown,
		       latch_shown, status_out, control_out,
		output ready
	);
endinterface

@@ design/ecx_cfg_regs.sv @@
// APB-style register block holding the two per-channel position gains.
module ecx_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ecx_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [ecx_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [ecx_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready,
	output ecx_pkg::gains_t                   gains
);
	import ecx_pkg::*;

	logic     wr_en;
	cfg_reg_t reg_sel;
	gains_t   gains_q;

	// Word address selects the register; the two low bits are byte offsets.
	assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.first  <= GAIN_RESET;
			gains_q.second <= GAIN_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_GAIN_FIRST:  gains_q.first  <= pwdata;
				REG_GAIN_SECOND: gains_q.second <= pwdata;
				default: ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		unique case (reg_sel)
			REG_GAIN_FIRST:  prdata = gains_q.first;
			REG_GAIN_SECOND: prdata = gains_q.second;
			default:         prdata = '0;
		endcase
	end

	assign gains = gains_q;

endmodule

@@ design/encoder_count_extender_with_index_latch_core.sv @@
// Top level of the encoder count extender with index latch.
//
// Each sample beat updates its channel's 16-bit raw count history and 32-bit extended count
// and produces exactly one result beat. The block takes a new sample in every clock cycle,
// for any mix of channels, while the result side does not stall it. An accepted sample
// passes the input register, while the count and latch logic works out the channel's
// new state, then the count register, while the signed 32 by 32 bit gain multiplication
// gives the Q48.16 position, and then the result register. Back-pressure on the result
// side stalls the pipeline stage by stage, and sample ready falls only when all three
// registers are full. The gains are set and read through an APB-style port at byte
// addresses 0 and 4 and must be written only while no sample is in flight. There is no
// start-up sweep: the per-channel state resets at once.
module encoder_count_extender_with_index_latch_core #(
	parameter int CHANNELS = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ecx_sample_if.sink                        samples,
	ecx_result_if.source                      results,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ecx_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [ecx_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [ecx_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import ecx_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	gains_t gains;

	// Pipeline control.
	logic v_s1, v_s2, v_s3;
	logic acc, adv2, adv3;

	// Input register.
	logic                       ch_s1;
	logic                       oper_s1;
	logic signed [RAW_W-1:0]    raw_s1;
	logic signed [RAW_W-1:0]    latched_s1;
	logic [STATUS_W-1:0]        status_s1;
	logic                       clear_s1;
	logic [CTRL_W-1:0]          ctrl_s1;

	// Count register.
	logic                       ch_s2;
	logic signed [COUNT_W-1:0]  count_s2;
	logic signed [GAIN_W-1:0]   gain_s2;
	logic signed [RAW_W-1:0]    raw_shown_s2;
	logic signed [RAW_W-1:0]    latch_shown_s2;
	logic [SHOWN_W-1:0]         status_s2;
	logic [CTRL_W-1:0]          ctrl_s2;

	// Result register.
	logic                       ch_s3;
	logic signed [COUNT_W-1:0]  count_s3;
	logic signed [POS_W-1:0]    pos_s3;
	logic signed [RAW_W-1:0]    raw_shown_s3;
	logic signed [RAW_W-1:0]    latch_shown_s3;
	logic [SHOWN_W-1:0]         status_s3;
	logic [CTRL_W-1:0]          ctrl_s3;

	// Per-channel state.
	logic [RAW_W-1:0]           prev_raw_q    [CHANNELS];
	logic [COUNT_W-1:0]         count_q       [CHANNELS];
	logic                       needs_start_q [CHANNELS];
	logic                       was_running_q [CHANNELS];
	logic [RAW_W-1:0]           held_raw_q    [CHANNELS];
	logic [RAW_W-1:0]           held_latch_q  [CHANNELS];
	logic [SHOWN_W-1:0]         held_status_q [CHANNELS];

	// Next-state logic for the sample in the input register.
	logic [CH_W-1:0]            ch_idx;
	logic [RAW_W-1:0]           last;
	logic [RAW_W-1:0]           delta;
	logic [COUNT_W-1:0]         base;
	logic [COUNT_W-1:0]         count_next;
	logic [CTRL_W-1:0]          ctrl_next;
	logic [RAW_W-1:0]           held_raw_next;
	logic [RAW_W-1:0]           held_latch_next;
	logic                       zero_count;

	ecx_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	// Handshake: each stage moves on when the one after it is empty or moving too.
	assign adv3          = v_s2 && (!v_s3 || results.ready);
	assign adv2          = v_s1 && (!v_s2 || adv3);
	assign samples.ready = !v_s1 || adv2;
	assign acc           = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv2) begin
				v_s1 <= 1'b0;
			end
			if (adv2) begin
				v_s2 <= 1'b1;
			end else if (adv3) begin
				v_s2 <= 1'b0;
			end
			if (adv3) begin
				v_s3 <= 1'b1;
			end else if (results.ready) begin
				v_s3 <= 1'b0;
			end
		end
	end

	// Input register capture.
	always_ff @(posedge clk) begin
		if (acc) begin
			ch_s1      <= samples.channel;
			oper_s1    <= samples.operational;
			raw_s1     <= samples.raw_sample;
			latched_s1 <= samples.raw_latched;
			status_s1  <= samples.status_flags;
			clear_s1   <= samples.clear_request;
			ctrl_s1    <= samples.control_flags;
		end
	end

	// Channel number beyond the channel count falls on the last channel.
	always_comb begin
		if (int'(ch_s1) < CHANNELS) begin
			ch_idx = CH_W'(ch_s1);
		end else begin
			ch_idx = CH_W'(CHANNELS - 1);
		end
	end

	// Count extension and latch handling; later events override the reference point.
	always_comb begin
		last       = prev_raw_q[ch_idx];
		ctrl_next  = ctrl_s1;
		zero_count = 1'b0;
		held_latch_next = held_latch_q[ch_idx];
		if (status_s1[ST_SET_DONE]) begin
			last = raw_s1;
			ctrl_next[CT_SET_RAW] = 1'b0;
		end
		if (!was_running_q[ch_idx]) begin
			last = raw_s1;
		end
		held_raw_next = ctrl_next[CT_SET_RAW] ? held_raw_q[ch_idx] : raw_s1;
		if (needs_start_q[ch_idx] || clear_s1) begin
			last = raw_s1;
			zero_count = 1'b1;
		end
		if (status_s1[ST_EXT_LATCH]) begin
			held_latch_next = latched_s1;
			last = latched_s1;
			zero_count = 1'b1;
			ctrl_next[CT_EN_EXT_POS] = 1'b0;
			ctrl_next[CT_EN_EXT_NEG] = 1'b0;
		end
		if (status_s1[ST_C_LATCH]) begin
			held_latch_next = latched_s1;
			last = latched_s1;
			zero_count = 1'b1;
			ctrl_next[CT_EN_C] = 1'b0;
		end
		delta      = raw_s1 - last;
		base       = zero_count ? '0 : count_q[ch_idx];
		count_next = base + {{(COUNT_W-RAW_W){delta[RAW_W-1]}}, delta};
	end

	// Channel state update as the sample leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				prev_raw_q[i]    <= '0;
				count_q[i]       <= '0;
				needs_start_q[i] <= 1'b1;
				was_running_q[i] <= 1'b0;
				held_raw_q[i]    <= '0;
				held_latch_q[i]  <= '0;
				held_status_q[i] <= '0;
			end
		end else if (adv2) begin
			if (!oper_s1) begin
				was_running_q[ch_idx] <= 1'b0;
			end else begin
				prev_raw_q[ch_idx]    <= raw_s1;
				count_q[ch_idx]       <= count_next;
				needs_start_q[ch_idx] <= 1'b0;
				was_running_q[ch_idx] <= 1'b1;
				held_raw_q[ch_idx]    <= held_raw_next;
				held_latch_q[ch_idx]  <= held_latch_next;
				held_status_q[ch_idx] <= status_s1[SHOWN_W-1:0];
			end
		end
	end

	// Count register: a sample that is not operational shows the held values.
	always_ff @(posedge clk) begin
		if (adv2) begin
			ch_s2   <= ch_s1;
			gain_s2 <= ch_s1 ? gains.second : gains.first;
			if (oper_s1) begin
				count_s2       <= count_next;
				raw_shown_s2   <= held_raw_next;
				latch_shown_s2 <= held_latch_next;
				status_s2      <= status_s1[SHOWN_W-1:0];
				ctrl_s2        <= ctrl_next;
			end else begin
				count_s2       <= count_q[ch_idx];
				raw_shown_s2   <= held_raw_q[ch_idx];
				latch_shown_s2 <= held_latch_q[ch_idx];
				status_s2      <= held_status_q[ch_idx];
				ctrl_s2        <= ctrl_s1;
			end
		end
	end

	// Result register with the gain multiplication.
	always_ff @(posedge clk) begin
		if (adv3) begin
			ch_s3          <= ch_s2;
			count_s3       <= count_s2;
			pos_s3         <= count_s2 * gain_s2;
			raw_shown_s3   <= raw_shown_s2;
			latch_shown_s3 <= latch_shown_s2;
			status_s3      <= status_s2;
			ctrl_s3        <= ctrl_s2;
		end
	end

	assign results.valid          = v_s3;
	assign results.channel_echo   = ch_s3;
	assign results.extended_count = count_s3;
	assign results.position       = pos_s3;
	assign results.raw_shown      = raw_shown_s3;
	assign results.latch_shown    = latch_shown_s3;
	assign results.status_out     = status_s3;
	assign results.control_out    = ctrl_s3;

	// A clear without latch events starts the count at zero.
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && oper_s1 && clear_s1 && !status_s1[ST_EXT_LATCH] && !status_s1[ST_C_LATCH]
		|=> count_s2 == '0)
		else $error("clear request did not zero the extended count");

	// After an operational beat its channel no longer waits for a start.
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && oper_s1 |=> !needs_start_q[$past(ch_idx)] && was_running_q[$past(ch_idx)])
		else $error("channel start flags not updated by an operational beat");

	// Sample ready only falls with the whole pipeline full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> v_s1 && v_s2 && v_s3 && !results.ready)
		else $error("sample ready low while the pipeline has room");

	// A stalled count stage holds its beat.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv3 && !adv2 |=> v_s2 && $stable(count_s2) && $stable(ch_s2))
		else $error("count stage changed while stalled");

endmodule
